// ----- hw/rtl/teq_pkg.sv -----
package teq_pkg;

  localparam int POLE_COUNT  = 4;
  localparam int POLE_W      = (POLE_COUNT > 1) ? $clog2(POLE_COUNT) : 1;
  localparam int HIST_DEPTH  = 3;
  localparam int SAMPLE_W    = 24;
  localparam int COEF_W      = 17;
  localparam int GAIN_W      = 10;
  localparam int STAGE_W     = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  localparam logic [COEF_W-1:0] LOW_COEF_RESET  = 17'd8212;
  localparam logic [COEF_W-1:0] HIGH_COEF_RESET = 17'd45709;
  localparam logic [GAIN_W-1:0] GAIN_RESET      = 10'd256;

  localparam logic CASC_LOW  = 1'b0;
  localparam logic CASC_HIGH = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LOW_COEF,
    REG_HIGH_COEF,
    REG_LOW_GAIN,
    REG_MID_GAIN,
    REG_HIGH_GAIN
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BAND_LOW,
    BAND_MID,
    BAND_HIGH
  } band_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_IN,
    OP_PREP,
    OP_MUL,
    OP_ACC,
    OP_BPREP,
    OP_BSUM,
    OP_FINAL,
    OP_LOAD_OUT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              ch;
    logic              casc;
    logic [POLE_W-1:0] pole;
    band_t             band;
  } teq_cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } teq_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } teq_out_t;

endpackage

// ----- hw/rtl/teq_ctrl.sv -----
module teq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_stall,
  output logic              in_stall,
  output logic              out_valid,
  output teq_pkg::teq_cmd_t cmd
);
  import teq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_ACC,
    S_BPREP,
    S_BMUL,
    S_BSUM,
    S_FINAL,
    S_DONE
  } state_t;

  localparam logic [POLE_W-1:0] POLE_LAST = POLE_W'(POLE_COUNT - 1);

  state_t            state;
  logic              ch;
  logic              casc;
  logic [POLE_W-1:0] pole;
  band_t             band;
  logic              out_load;

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      ch        <= 1'b0;
      casc      <= CASC_LOW;
      pole      <= '0;
      band      <= BAND_LOW;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_PREP;
            ch    <= 1'b0;
            casc  <= CASC_LOW;
            pole  <= '0;
          end
        end
        S_PREP: state <= S_MUL;
        S_MUL:  state <= S_ACC;
        S_ACC: begin
          if (pole == POLE_LAST) begin
            pole <= '0;
            if (casc == CASC_HIGH) begin
              casc  <= CASC_LOW;
              band  <= BAND_LOW;
              state <= S_BPREP;
            end else begin
              casc  <= CASC_HIGH;
              state <= S_PREP;
            end
          end else begin
            pole  <= pole + 1'b1;
            state <= S_PREP;
          end
        end
        S_BPREP: state <= S_BMUL;
        S_BMUL:  state <= S_BSUM;
        S_BSUM: begin
          case (band)
            BAND_LOW: begin
              band  <= BAND_MID;
              state <= S_BPREP;
            end
            BAND_MID: begin
              band  <= BAND_HIGH;
              state <= S_BPREP;
            end
            default: state <= S_FINAL;
          endcase
        end
        S_FINAL: begin
          if (ch) begin
            state <= S_DONE;
          end else begin
            ch    <= 1'b1;
            state <= S_PREP;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.ch   = ch;
    cmd.casc = casc;
    cmd.pole = pole;
    cmd.band = band;
    case (state)
      S_IDLE:  cmd.op = in_valid ? OP_LOAD_IN : OP_NONE;
      S_PREP:  cmd.op = OP_PREP;
      S_MUL:   cmd.op = OP_MUL;
      S_ACC:   cmd.op = OP_ACC;
      S_BPREP: cmd.op = OP_BPREP;
      S_BMUL:  cmd.op = OP_MUL;
      S_BSUM:  cmd.op = OP_BSUM;
      S_FINAL: cmd.op = OP_FINAL;
      S_DONE:  cmd.op = out_load ? OP_LOAD_OUT : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

// ----- hw/rtl/teq_dpath.sv -----
module teq_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  teq_pkg::teq_cmd_t                cmd,
  input  logic                             cfg_write,
  input  logic [teq_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [teq_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  teq_pkg::teq_in_t                 in_data,
  output teq_pkg::teq_out_t                out_data
);
  import teq_pkg::*;

  logic [COEF_W-1:0] low_coef;
  logic [COEF_W-1:0] high_coef;
  logic [GAIN_W-1:0] low_gain;
  logic [GAIN_W-1:0] mid_gain;
  logic [GAIN_W-1:0] high_gain;

  logic signed [STAGE_W-1:0]  stages [2][2][POLE_COUNT];
  logic signed [SAMPLE_W-1:0] hist   [2][HIST_DEPTH];
  logic signed [SAMPLE_W-1:0] sample [2];
  logic signed [SAMPLE_W-1:0] res    [2];

  logic signed [STAGE_W-1:0] run;
  logic signed [STAGE_W-1:0] lo_band;
  logic signed [STAGE_W-1:0] hp_band;
  logic signed [32:0]        opa;
  logic signed [17:0]        opb;
  logic signed [50:0]        prod;
  logic signed [47:0]        acc;

  logic signed [STAGE_W-1:0] st_cur;
  logic signed [STAGE_W-1:0] x_cur;
  logic signed [STAGE_W-1:0] prev_val;
  logic signed [32:0]        diff;
  logic [COEF_W-1:0]         coef_sel;
  logic signed [50:0]        rnd_stage;
  logic signed [34:0]        step;
  logic signed [35:0]        n_wide;
  logic signed [STAGE_W-1:0] n_sat;
  logic signed [STAGE_W-1:0] delayed;
  logic signed [32:0]        hi_band;
  logic signed [32:0]        mid_band;
  logic signed [32:0]        band_val;
  logic [GAIN_W-1:0]         gain_sel;
  logic signed [47:0]        acc_next;
  logic signed [47:0]        rnd_out;
  logic signed [31:0]        sh_out;
  logic signed [SAMPLE_W-1:0] out_sat;

  assign st_cur    = stages[cmd.ch][cmd.casc][cmd.pole];
  assign x_cur     = $signed({sample[cmd.ch], 8'b0});
  assign prev_val  = (cmd.pole == '0) ? x_cur : run;
  assign diff      = $signed({prev_val[STAGE_W-1], prev_val}) -
                     $signed({st_cur[STAGE_W-1], st_cur});
  assign coef_sel  = (cmd.casc == CASC_HIGH) ? high_coef : low_coef;

  assign rnd_stage = prod + 51'sd32768;
  assign step      = rnd_stage[50:16];
  assign n_wide    = $signed({{4{st_cur[STAGE_W-1]}}, st_cur}) +
                     $signed({step[34], step});
  assign n_sat     = (n_wide[35:31] == {5{n_wide[35]}}) ? n_wide[31:0] :
                     (n_wide[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  assign delayed   = $signed({hist[cmd.ch][HIST_DEPTH-1], 8'b0});
  assign hi_band   = $signed({delayed[31], delayed}) - $signed({hp_band[31], hp_band});
  assign mid_band  = $signed({hp_band[31], hp_band}) - $signed({lo_band[31], lo_band});

  always_comb begin
    case (cmd.band)
      BAND_LOW: begin
        band_val = $signed({lo_band[31], lo_band});
        gain_sel = low_gain;
      end
      BAND_MID: begin
        band_val = mid_band;
        gain_sel = mid_gain;
      end
      default: begin
        band_val = hi_band;
        gain_sel = high_gain;
      end
    endcase
  end

  assign acc_next = ((cmd.band == BAND_LOW) ? 48'sd0 : acc) + prod[47:0];
  assign rnd_out  = acc + 48'sd32768;
  assign sh_out   = rnd_out[47:16];
  assign out_sat  = (sh_out[31:23] == {9{sh_out[31]}}) ? sh_out[23:0] :
                    (sh_out[31] ? 24'sh80_0000 : 24'sh7F_FFFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      low_coef  <= LOW_COEF_RESET;
      high_coef <= HIGH_COEF_RESET;
      low_gain  <= GAIN_RESET;
      mid_gain  <= GAIN_RESET;
      high_gain <= GAIN_RESET;
      for (int c = 0; c < 2; c++) begin
        for (int k = 0; k < 2; k++) begin
          for (int p = 0; p < POLE_COUNT; p++) begin
            stages[c][k][p] <= '0;
          end
        end
        for (int h = 0; h < HIST_DEPTH; h++) begin
          hist[c][h] <= '0;
        end
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_LOW_COEF:  low_coef  <= cfg_data[COEF_W-1:0];
          REG_HIGH_COEF: high_coef <= cfg_data[COEF_W-1:0];
          REG_LOW_GAIN:  low_gain  <= cfg_data[GAIN_W-1:0];
          REG_MID_GAIN:  mid_gain  <= cfg_data[GAIN_W-1:0];
          REG_HIGH_GAIN: high_gain <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_ACC) begin
        stages[cmd.ch][cmd.casc][cmd.pole] <= n_sat;
      end
      if (cmd.op == OP_FINAL) begin
        for (int h = HIST_DEPTH - 1; h > 0; h--) begin
          hist[cmd.ch][h] <= hist[cmd.ch][h-1];
        end
        hist[cmd.ch][0] <= sample[cmd.ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD_IN: begin
        sample[0] <= in_data.left_in;
        sample[1] <= in_data.right_in;
      end
      OP_PREP: begin
        opa <= diff;
        opb <= $signed({1'b0, coef_sel});
      end
      OP_MUL: prod <= opa * opb;
      OP_ACC: begin
        run <= n_sat;
        if (cmd.casc == CASC_HIGH) begin
          hp_band <= n_sat;
        end else begin
          lo_band <= n_sat;
        end
      end
      OP_BPREP: begin
        opa <= band_val;
        opb <= $signed({8'b0, gain_sel});
      end
      OP_BSUM:  acc <= acc_next;
      OP_FINAL: res[cmd.ch] <= out_sat;
      OP_LOAD_OUT: begin
        out_data.left_out  <= res[0];
        out_data.right_out <= res[1];
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/three_band_equalizer.sv -----
// One stereo frame is in progress at a time: in_stall stays high after an input is
// accepted until the result is loaded into the output register, as the single shared
// multiplier steps through every filter pole and band gain in turn.
// A finished result waits in the output register while the next frame is accepted.
// Reset (rst, synchronous) clears filter state, input history and handshake state,
// and loads the default coefficients and unity gains.
module three_band_equalizer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  teq_pkg::teq_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output teq_pkg::teq_out_t               out_data,
  input  logic                            cfg_write,
  input  logic [teq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [teq_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import teq_pkg::*;

  teq_cmd_t cmd;

  teq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  teq_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/teq_checker.sv -----
module teq_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input teq_pkg::teq_out_t out_data
);

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed or dropped");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off while a frame is in progress");

  assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("handshake not idle after reset");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output transaction appeared with no frame in progress");

endmodule

bind three_band_equalizer teq_checker u_teq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
